FILE: sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rau_pkg;

  localparam int DEF_WIDTH = 32;
  // bits of the multiplier operand consumed per cycle
  localparam int MUL_DIGIT = 8;

  typedef enum logic [3:0] {
    OP_ADD       = 4'd0,
    OP_SUB       = 4'd1,
    OP_MUL       = 4'd2,
    OP_DIV       = 4'd3,
    OP_MOD       = 4'd4,
    OP_FLOOR_DIV = 4'd5,
    OP_POW       = 4'd6,
    OP_NEG       = 4'd7,
    OP_ABS       = 4'd8,
    OP_FLOOR     = 4'd9,
    OP_CEIL      = 4'd10
  } op_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO_DIV = 2'd1,
    ERR_EXP      = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    MS_CROSS = 3'd0,
    MS_NN    = 3'd1,
    MS_DIV   = 3'd2,
    MS_DD    = 3'd3,
    MS_ACC   = 3'd4,
    MS_SQ    = 3'd5
  } mul_sel_e;

  typedef enum logic [1:0] {
    DS_PQ    = 2'd0,
    DS_ROUND = 2'd1,
    DS_NUMG  = 2'd2,
    DS_DENG  = 2'd3
  } div_sel_e;

  typedef enum logic [4:0] {
    RS_NONE     = 5'd0,
    RS_ZERO     = 5'd1,
    RS_NEG      = 5'd2,
    RS_ABS      = 5'd3,
    RS_SAT      = 5'd4,
    RS_POW_INIT = 5'd5,
    RS_ADDSUB   = 5'd6,
    RS_MUL      = 5'd7,
    RS_DIV      = 5'd8,
    RS_MOD      = 5'd9,
    RS_FDIV     = 5'd10,
    RS_ROUND    = 5'd11,
    RS_RED_ZERO = 5'd12,
    RS_RED_INF  = 5'd13,
    RS_RED_N    = 5'd14,
    RS_RED_D    = 5'd15,
    RS_POW_ACC  = 5'd16
  } res_sel_e;

  typedef struct packed {
    logic     load;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     lat_pq;
    logic     lat_d;
    logic     k_shift;
    logic     div_go;
    div_sel_e div_sel;
    logic     gcd_go;
    res_sel_e res_sel;
    err_e     err;
  } rau_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       mul_done;
    logic       div_done;
    logic       gcd_done;
    logic       q_zero;
    logic       bd_one;
    logic       ad_zero;
    logic       k_zero;
    logic       k_odd;
    logic       rn_zero;
    logic       rd_zero;
  } rau_stat_t;

endpackage

FILE: sv/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul
// Digit-serial multiplier, product wraps at WIDTH bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_mul
  import rau_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  localparam int STEPS = (WIDTH + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int CW    = $clog2(STEPS + 1);

  logic [WIDTH-1:0] acc_q, acc_d, a_q, a_d, b_q, b_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      acc_d  = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = CW'(STEPS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = acc_q + a_q * WIDTH'(b_q[MUL_DIGIT-1:0]);
      a_d   = a_q << MUL_DIGIT;
      b_d   = b_q >> MUL_DIGIT;
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: sv/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_div
  import rau_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [WIDTH-1:0] n_i,
  input  logic [WIDTH-1:0] d_i,
  output logic             done_o,
  output logic [WIDTH-1:0] quot_o,
  output logic [WIDTH-1:0] rem_o
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [WIDTH:0]   shifted;
  logic             fits;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[WIDTH-1]};
    fits    = shifted >= {1'b0, dvs_q};
    if (go_i) begin
      quo_d  = n_i;
      rem_d  = '0;
      dvs_d  = d_i;
      cnt_d  = CW'(WIDTH);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? WIDTH'(shifted - {1'b0, dvs_q}) : shifted[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], fits};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: sv/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd of two nonzero unsigned values, one step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_gcd
  import rau_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             go_i,
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  output logic             done_o,
  output logic [WIDTH-1:0] g_o
);

  localparam int SW = $clog2(WIDTH);

  logic [WIDTH-1:0] u_q, u_d, v_q, v_d, g_q, g_d;
  logic [SW-1:0]    sh_q, sh_d;
  logic             busy_q, busy_d, done_q, done_d;

  always_comb begin
    u_d    = u_q;
    v_d    = v_q;
    g_d    = g_q;
    sh_d   = sh_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (go_i) begin
      u_d    = a_i;
      v_d    = b_i;
      sh_d   = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (u_q == '0 || v_q == '0) begin
        g_d    = (u_q | v_q) << sh_q;
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (!u_q[0] && !v_q[0]) begin
        // common factor of two
        u_d  = u_q >> 1;
        v_d  = v_q >> 1;
        sh_d = sh_q + SW'(1);
      end else if (!u_q[0]) begin
        u_d = u_q >> 1;
      end else if (!v_q[0]) begin
        v_d = v_q >> 1;
      end else if (u_q >= v_q) begin
        u_d = u_q - v_q;
      end else begin
        v_d = v_q - u_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q  <= u_d;
    v_q  <= v_d;
    g_q  <= g_d;
    sh_q <= sh_d;
  end

  assign done_o = done_q;
  assign g_o    = g_q;

endmodule

FILE: sv/rau_dpath.sv
// ----------------------------------------------------------------------------
// rau_dpath
// Operand and result registers with the shared multiply, divide and gcd units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_dpath
  import rau_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rau_cmd_t           cmd_i,
  output rau_stat_t          stat_o,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] a_num_i,
  input  logic [31:0]        a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic [31:0]        b_den_i,
  output logic signed [31:0] res_num_o,
  output logic [31:0]        res_den_o,
  output logic [1:0]         error_o
);

  localparam logic [WIDTH-1:0] ONE  = WIDTH'(1);
  localparam logic [WIDTH-1:0] WMAX = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] WMIN = {1'b1, {(WIDTH-1){1'b0}}};

  function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] x);
    return x[WIDTH-1] ? -x : x;
  endfunction

  logic [3:0]       op_q, op_d;
  logic [WIDTH-1:0] an_q, an_d, ad_q, ad_d, bn_q, bn_d, bd_q, bd_d;
  logic [WIDTH-1:0] p_q, p_d, q_q, q_d, d_q, d_d, k_q, k_d;
  logic [WIDTH-1:0] rn_q, rn_d, rd_q, rd_d;
  logic [1:0]       err_q, err_d;

  logic [WIDTH-1:0] m0_a, m0_b, m1_a, m1_b, m0_prod, m1_prod;
  logic [WIDTH-1:0] dv_n, dv_d, quot, rem, gcd_val, adj;
  logic             m0_done, m1_done, div_done, gcd_done, inc, up, sneg;

  always_comb begin
    m0_a = an_q;
    m0_b = bd_q;
    m1_a = bn_q;
    m1_b = ad_q;
    case (cmd_i.mul_sel)
      MS_CROSS: begin
        m0_a = an_q; m0_b = bd_q; m1_a = bn_q; m1_b = ad_q;
      end
      MS_NN: begin
        m0_a = an_q; m0_b = bn_q; m1_a = ad_q; m1_b = bd_q;
      end
      MS_DIV: begin
        m0_a = an_q; m0_b = bd_q; m1_a = ad_q; m1_b = mag(bn_q);
      end
      MS_DD: begin
        m0_a = ad_q; m0_b = bd_q; m1_a = ad_q; m1_b = bd_q;
      end
      MS_ACC: begin
        m0_a = rn_q; m0_b = p_q; m1_a = rd_q; m1_b = q_q;
      end
      MS_SQ: begin
        m0_a = p_q; m0_b = p_q; m1_a = q_q; m1_b = q_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    dv_n = mag(p_q);
    dv_d = mag(q_q);
    case (cmd_i.div_sel)
      DS_PQ: begin
        dv_n = mag(p_q); dv_d = mag(q_q);
      end
      DS_ROUND: begin
        dv_n = mag(an_q); dv_d = ad_q;
      end
      DS_NUMG: begin
        dv_n = mag(rn_q); dv_d = gcd_val;
      end
      DS_DENG: begin
        dv_n = rd_q; dv_d = gcd_val;
      end
      default: ;
    endcase
  end

  rau_mul #(.WIDTH(WIDTH)) u_mul0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .a_i    (m0_a),
    .b_i    (m0_b),
    .done_o (m0_done),
    .prod_o (m0_prod)
  );

  // runs in lockstep with u_mul0
  rau_mul #(.WIDTH(WIDTH)) u_mul1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.mul_go),
    .a_i    (m1_a),
    .b_i    (m1_b),
    .done_o (m1_done),
    .prod_o (m1_prod)
  );

  rau_div #(.WIDTH(WIDTH)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.div_go),
    .n_i    (dv_n),
    .d_i    (dv_d),
    .done_o (div_done),
    .quot_o (quot),
    .rem_o  (rem)
  );

  rau_gcd #(.WIDTH(WIDTH)) u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (cmd_i.gcd_go),
    .a_i    (mag(rn_q)),
    .b_i    (rd_q),
    .done_o (gcd_done),
    .g_o    (gcd_val)
  );

  always_comb begin
    op_d  = op_q;
    an_d  = an_q;
    ad_d  = ad_q;
    bn_d  = bn_q;
    bd_d  = bd_q;
    p_d   = p_q;
    q_d   = q_q;
    d_d   = d_q;
    k_d   = k_q;
    rn_d  = rn_q;
    rd_d  = rd_q;
    err_d = err_q;
    up    = (op_q == OP_CEIL);
    sneg  = p_q[WIDTH-1] ^ q_q[WIDTH-1];
    inc   = 1'b0;
    adj   = '0;

    if (cmd_i.load) begin
      op_d  = op_i;
      an_d  = WIDTH'(a_num_i);
      ad_d  = WIDTH'(a_den_i);
      bn_d  = WIDTH'(b_num_i);
      bd_d  = WIDTH'(b_den_i);
      err_d = ERR_OK;
    end
    if (cmd_i.lat_pq) begin
      p_d = m0_prod;
      q_d = m1_prod;
    end
    if (cmd_i.lat_d) begin
      d_d = m0_prod;
    end
    if (cmd_i.k_shift) begin
      k_d = k_q >> 1;
    end

    case (cmd_i.res_sel)
      RS_NONE: ;
      RS_ZERO: begin
        rn_d  = '0;
        rd_d  = ONE;
        err_d = cmd_i.err;
      end
      RS_NEG: begin
        rn_d = -an_q;
        rd_d = ad_q;
      end
      RS_ABS: begin
        rn_d = mag(an_q);
        rd_d = ad_q;
      end
      RS_SAT: begin
        rn_d = (an_q == '0) ? '0 : (an_q[WIDTH-1] ? WMIN : WMAX);
        rd_d = ONE;
      end
      RS_POW_INIT: begin
        rn_d = ONE;
        rd_d = ONE;
        if (bn_q[WIDTH-1]) begin
          // negative exponent inverts the base, sign stays on top
          k_d = -bn_q;
          p_d = an_q[WIDTH-1] ? -ad_q : ad_q;
          q_d = an_q[WIDTH-1] ? -an_q : an_q;
        end else begin
          k_d = bn_q;
          p_d = an_q;
          q_d = ad_q;
        end
      end
      RS_ADDSUB: begin
        rn_d = (op_q == OP_SUB) ? p_q - q_q : p_q + q_q;
        rd_d = d_q;
      end
      RS_MUL: begin
        rn_d = p_q;
        rd_d = q_q;
      end
      RS_DIV: begin
        rn_d = bn_q[WIDTH-1] ? -p_q : p_q;
        rd_d = q_q;
      end
      RS_MOD: begin
        rn_d = p_q[WIDTH-1] ? -rem : rem;
        rd_d = d_q;
      end
      RS_FDIV: begin
        inc  = sneg && (rem != '0);
        adj  = quot + WIDTH'(inc);
        rn_d = sneg ? -adj : quot;
        rd_d = ONE;
      end
      RS_ROUND: begin
        inc  = (rem != '0) && (up ^ an_q[WIDTH-1]);
        adj  = quot + WIDTH'(inc);
        rn_d = an_q[WIDTH-1] ? -adj : adj;
        rd_d = ONE;
      end
      RS_RED_ZERO: rd_d = ONE;
      RS_RED_INF:  rn_d = ONE;
      RS_RED_N:    rn_d = rn_q[WIDTH-1] ? -quot : quot;
      RS_RED_D:    rd_d = quot;
      RS_POW_ACC: begin
        rn_d = m0_prod;
        rd_d = m1_prod;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    an_q  <= an_d;
    ad_q  <= ad_d;
    bn_q  <= bn_d;
    bd_q  <= bd_d;
    p_q   <= p_d;
    q_q   <= q_d;
    d_q   <= d_d;
    k_q   <= k_d;
    rn_q  <= rn_d;
    rd_q  <= rd_d;
    err_q <= err_d;
  end

  always_comb begin
    stat_o.op       = op_q;
    stat_o.mul_done = m0_done & m1_done;
    stat_o.div_done = div_done;
    stat_o.gcd_done = gcd_done;
    stat_o.q_zero   = (q_q == '0);
    stat_o.bd_one   = (bd_q == ONE);
    stat_o.ad_zero  = (ad_q == '0);
    stat_o.k_zero   = (k_q == '0);
    stat_o.k_odd    = k_q[0];
    stat_o.rn_zero  = (rn_q == '0);
    stat_o.rd_zero  = (rd_q == '0);
  end

  assign res_num_o = 32'($signed(rn_q));
  assign res_den_o = 32'(rd_q);
  assign error_o   = err_q;

endmodule

FILE: sv/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer that steps the datapath through each operation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rau_ctrl
  import rau_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  output rau_cmd_t  cmd_o,
  input  rau_stat_t stat_i
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_SETUP   = 15'h0002,
    S_MUL_A   = 15'h0004,
    S_POST_A  = 15'h0008,
    S_MUL_B   = 15'h0010,
    S_POST_B  = 15'h0020,
    S_DIVIDE  = 15'h0040,
    S_RED     = 15'h0080,
    S_GCD     = 15'h0100,
    S_RED_N   = 15'h0200,
    S_RED_D   = 15'h0400,
    S_POW_CHK = 15'h0800,
    S_POW_ACC = 15'h1000,
    S_POW_SQ  = 15'h2000,
    S_DONE    = 15'h4000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SETUP;
        end
      end
      S_SETUP: begin
        if (stat_i.op inside {OP_ADD, OP_SUB, OP_MOD, OP_FLOOR_DIV}) begin
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_sel = MS_CROSS;
          state_d       = S_MUL_A;
        end else if (stat_i.op == OP_MUL) begin
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_sel = MS_NN;
          state_d       = S_MUL_A;
        end else if (stat_i.op == OP_DIV) begin
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_sel = MS_DIV;
          state_d       = S_MUL_A;
        end else if (stat_i.op == OP_POW) begin
          if (!stat_i.bd_one) begin
            cmd_o.res_sel = RS_ZERO;
            cmd_o.err     = ERR_EXP;
            state_d       = S_DONE;
          end else begin
            cmd_o.res_sel = RS_POW_INIT;
            state_d       = S_POW_CHK;
          end
        end else if (stat_i.op == OP_NEG) begin
          cmd_o.res_sel = RS_NEG;
          state_d       = S_DONE;
        end else if (stat_i.op == OP_ABS) begin
          cmd_o.res_sel = RS_ABS;
          state_d       = S_DONE;
        end else if (stat_i.op inside {OP_FLOOR, OP_CEIL}) begin
          if (stat_i.ad_zero) begin
            cmd_o.res_sel = RS_SAT;
            state_d       = S_DONE;
          end else begin
            cmd_o.div_go  = 1'b1;
            cmd_o.div_sel = DS_ROUND;
            state_d       = S_DIVIDE;
          end
        end else begin
          cmd_o.res_sel = RS_ZERO;
          cmd_o.err     = ERR_OK;
          state_d       = S_DONE;
        end
      end
      S_MUL_A: begin
        if (stat_i.mul_done) begin
          cmd_o.lat_pq = 1'b1;
          state_d      = S_POST_A;
        end
      end
      S_POST_A: begin
        if (stat_i.op inside {OP_ADD, OP_SUB, OP_MOD}) begin
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_sel = MS_DD;
          state_d       = S_MUL_B;
        end else if (stat_i.op == OP_MUL) begin
          cmd_o.res_sel = RS_MUL;
          state_d       = S_RED;
        end else if (stat_i.op == OP_DIV) begin
          cmd_o.res_sel = RS_DIV;
          state_d       = S_RED;
        end else if (stat_i.q_zero) begin
          cmd_o.res_sel = RS_ZERO;
          cmd_o.err     = ERR_ZERO_DIV;
          state_d       = S_DONE;
        end else begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = DS_PQ;
          state_d       = S_DIVIDE;
        end
      end
      S_MUL_B: begin
        if (stat_i.mul_done) begin
          cmd_o.lat_d = 1'b1;
          state_d     = S_POST_B;
        end
      end
      S_POST_B: begin
        if (stat_i.op != OP_MOD) begin
          cmd_o.res_sel = RS_ADDSUB;
          state_d       = S_RED;
        end else if (stat_i.q_zero) begin
          cmd_o.res_sel = RS_ZERO;
          cmd_o.err     = ERR_ZERO_DIV;
          state_d       = S_DONE;
        end else begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = DS_PQ;
          state_d       = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (stat_i.div_done) begin
          if (stat_i.op == OP_MOD) begin
            cmd_o.res_sel = RS_MOD;
            state_d       = S_RED;
          end else if (stat_i.op == OP_FLOOR_DIV) begin
            cmd_o.res_sel = RS_FDIV;
            state_d       = S_DONE;
          end else begin
            cmd_o.res_sel = RS_ROUND;
            state_d       = S_DONE;
          end
        end
      end
      S_RED: begin
        if (stat_i.rn_zero) begin
          cmd_o.res_sel = RS_RED_ZERO;
          state_d       = S_DONE;
        end else if (stat_i.rd_zero) begin
          // infinity keeps no sign
          cmd_o.res_sel = RS_RED_INF;
          state_d       = S_DONE;
        end else begin
          cmd_o.gcd_go = 1'b1;
          state_d      = S_GCD;
        end
      end
      S_GCD: begin
        if (stat_i.gcd_done) begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_sel = DS_NUMG;
          state_d       = S_RED_N;
        end
      end
      S_RED_N: begin
        cmd_o.div_sel = DS_DENG;
        if (stat_i.div_done) begin
          cmd_o.res_sel = RS_RED_N;
          cmd_o.div_go  = 1'b1;
          state_d       = S_RED_D;
        end
      end
      S_RED_D: begin
        if (stat_i.div_done) begin
          cmd_o.res_sel = RS_RED_D;
          state_d       = S_DONE;
        end
      end
      S_POW_CHK: begin
        cmd_o.mul_sel = stat_i.k_odd ? MS_ACC : MS_SQ;
        if (stat_i.k_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o.mul_go = 1'b1;
          state_d      = stat_i.k_odd ? S_POW_ACC : S_POW_SQ;
        end
      end
      S_POW_ACC: begin
        cmd_o.mul_sel = MS_SQ;
        if (stat_i.mul_done) begin
          cmd_o.res_sel = RS_POW_ACC;
          cmd_o.mul_go  = 1'b1;
          state_d       = S_POW_SQ;
        end
      end
      S_POW_SQ: begin
        if (stat_i.mul_done) begin
          cmd_o.lat_pq  = 1'b1;
          cmd_o.k_shift = 1'b1;
          state_d       = S_POW_CHK;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

`ifndef ASSERT_OFF
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("accepted word did not raise busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe while idle");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o && start_i) else $error("operand load outside idle");
`endif

endmodule

FILE: sv/rational_arith_unit.sv
// ----------------------------------------------------------------------------
// rational_arith_unit
// Exact rational ALU with gcd reduction over WIDTH-bit fractions.
// Sequence: neg, abs, pow error and unknown ops finish from setup; floor and
//   ceil run one divide; floor_div and mod add a divide to the multiplies;
//   add, sub, mul, div, mod then reduce with the gcd unit and two divides on
//   top of the multiplies; pow runs a square per exponent bit, with an
//   accumulate multiply before it for each odd bit.
// Throughput: one word at a time, a new word is taken in the cycle after the
//   strobe; the result strobe lasts one cycle and cannot be stalled.
// Reset: asynchronous active low, returns the sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_arith_unit
  import rau_pkg::*;
#(
  parameter int WIDTH = DEF_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         op_i,
  input  logic signed [31:0] a_num_i,
  input  logic [31:0]        a_den_i,
  input  logic signed [31:0] b_num_i,
  input  logic [31:0]        b_den_i,
  output logic               done_o,
  output logic signed [31:0] res_num_o,
  output logic [31:0]        res_den_o,
  output logic [1:0]         error_o
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd),
    .stat_i  (stat)
  );

  rau_dpath #(.WIDTH(WIDTH)) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .op_i      (op_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .res_num_o (res_num_o),
    .res_den_o (res_den_o),
    .error_o   (error_o)
  );

endmodule
